// ----- hw/rtl/ckst_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ckst_pkg
// Shared types, constants and keyframe angle table for the cubic keyframe
// servo trajectory block.
// ----------------------------------------------------------------------------
package ckst_pkg;

   localparam int ANGLE_BITS = 8;
   localparam int PULSE_BITS = 12;
   localparam int ROW_BITS   = 6;
   localparam int DUR_BITS   = 12;
   localparam int JOINT_MAX  = 8;
   localparam int JOINT_BITS = 3;
   localparam int QUOT_BITS  = 13;   // pulse offset quotient stays below 8192
   localparam int ROM_ROWS   = 40;
   localparam int ANGLE_SPAN = 180;
   localparam int PULSE_MAX  = 4095;

   // x / 180 == ((x >> 2) * ceil(2^24 / 45)) >> 24, exact for x below 2^20
   localparam int RECIP_MUL   = 372828;
   localparam int RECIP_BITS  = 19;
   localparam int RECIP_SHIFT = 24;

   localparam logic ACT_START = 1'b0;
   localparam logic ACT_TICK  = 1'b1;

   localparam logic REG_PULSE_LOW  = 1'b0;
   localparam logic REG_PULSE_HIGH = 1'b1;

   typedef struct packed {
      logic                action;
      logic [ROW_BITS-1:0] start_index;
      logic [ROW_BITS-1:0] end_index;
      logic [DUR_BITS-1:0] duration_ms;
   } req_type;

   typedef struct packed {
      logic [PULSE_BITS-1:0] pulse_joint0;
      logic [PULSE_BITS-1:0] pulse_joint1;
      logic [PULSE_BITS-1:0] pulse_joint2;
      logic [PULSE_BITS-1:0] pulse_joint3;
      logic [PULSE_BITS-1:0] pulse_joint4;
      logic [PULSE_BITS-1:0] pulse_joint5;
      logic [PULSE_BITS-1:0] pulse_joint6;
      logic [PULSE_BITS-1:0] pulse_joint7;
      logic [ROW_BITS-1:0]   segment_row;
      logic                  move_done;
   } rsp_type;

   // joint 0 sits in the top byte of a row
   function automatic logic [ANGLE_BITS-1:0] rom_angle(input logic [ROW_BITS-1:0] row,
                                                       input logic [JOINT_BITS-1:0] joint);
      logic [JOINT_MAX*ANGLE_BITS-1:0] r;
      logic [JOINT_BITS-1:0]           pos;
      unique case (row)
         6'd0:  r = {8'd47, 8'd156,8'd137,8'd32, 8'd100,8'd80, 8'd90, 8'd90};
         6'd1:  r = {8'd47, 8'd156,8'd137,8'd32, 8'd100,8'd10, 8'd90, 8'd15};
         6'd2:  r = {8'd47, 8'd156,8'd137,8'd32, 8'd170,8'd10, 8'd160,8'd15};
         6'd3:  r = {8'd47, 8'd144,8'd149,8'd32, 8'd170,8'd35, 8'd135,8'd15};
         6'd4:  r = {8'd47, 8'd131,8'd162,8'd32, 8'd170,8'd10, 8'd160,8'd15};
         6'd5:  r = {8'd35, 8'd131,8'd162,8'd44, 8'd145,8'd10, 8'd160,8'd40};
         6'd6:  r = {8'd22, 8'd131,8'd162,8'd57, 8'd170,8'd10, 8'd160,8'd15};
         6'd7:  r = {8'd47, 8'd156,8'd137,8'd32, 8'd145,8'd10, 8'd160,8'd40};
         6'd8:  r = {8'd72, 8'd181,8'd112,8'd7,  8'd170,8'd10, 8'd160,8'd15};
         6'd9:  r = {8'd47, 8'd156,8'd137,8'd32, 8'd170,8'd35, 8'd135,8'd15};
         6'd10: r = {8'd22, 8'd131,8'd162,8'd57, 8'd170,8'd10, 8'd160,8'd15};
         6'd11: r = {8'd47, 8'd156,8'd137,8'd32, 8'd170,8'd35, 8'd135,8'd15};
         6'd12: r = {8'd72, 8'd180,8'd112,8'd7,  8'd170,8'd10, 8'd160,8'd15};
         6'd13: r = {8'd47, 8'd156,8'd137,8'd32, 8'd145,8'd10, 8'd160,8'd40};
         6'd14: r = {8'd22, 8'd131,8'd162,8'd57, 8'd170,8'd10, 8'd160,8'd15};
         6'd15: r = {8'd47, 8'd156,8'd137,8'd32, 8'd170,8'd10, 8'd160,8'd15};
         6'd16: r = {8'd97, 8'd106,8'd87, 8'd82, 8'd120,8'd10, 8'd160,8'd65};
         6'd17: r = {8'd147,8'd56, 8'd37, 8'd132,8'd170,8'd10, 8'd160,8'd15};
         6'd18: r = {8'd97, 8'd106,8'd87, 8'd82, 8'd170,8'd60, 8'd110,8'd15};
         6'd19: r = {8'd47, 8'd156,8'd137,8'd32, 8'd170,8'd10, 8'd160,8'd15};
         6'd20: r = {8'd97, 8'd106,8'd87, 8'd82, 8'd170,8'd60, 8'd110,8'd15};
         6'd21: r = {8'd147,8'd56, 8'd37, 8'd132,8'd170,8'd10, 8'd160,8'd15};
         6'd22: r = {8'd97, 8'd106,8'd87, 8'd82, 8'd120,8'd10, 8'd160,8'd65};
         6'd23: r = {8'd47, 8'd156,8'd137,8'd32, 8'd170,8'd10, 8'd160,8'd15};
         6'd24: r = {8'd147,8'd56, 8'd37, 8'd132,8'd170,8'd10, 8'd160,8'd15};
         6'd25: r = {8'd147,8'd106,8'd87, 8'd132,8'd170,8'd60, 8'd110,8'd15};
         6'd26: r = {8'd147,8'd156,8'd137,8'd132,8'd170,8'd10, 8'd160,8'd15};
         6'd27: r = {8'd97, 8'd156,8'd137,8'd82, 8'd120,8'd10, 8'd160,8'd65};
         6'd28: r = {8'd47, 8'd156,8'd137,8'd32, 8'd170,8'd10, 8'd160,8'd15};
         6'd29: r = {8'd22, 8'd131,8'd162,8'd57, 8'd170,8'd10, 8'd160,8'd15};
         6'd30: r = {8'd22, 8'd144,8'd149,8'd57, 8'd170,8'd35, 8'd135,8'd15};
         6'd31: r = {8'd22, 8'd156,8'd137,8'd57, 8'd170,8'd10, 8'd160,8'd15};
         6'd32: r = {8'd35, 8'd156,8'd137,8'd44, 8'd145,8'd10, 8'd160,8'd40};
         6'd33: r = {8'd47, 8'd156,8'd137,8'd32, 8'd170,8'd10, 8'd160,8'd15};
         6'd34: r = {8'd72, 8'd180,8'd112,8'd7,  8'd170,8'd10, 8'd160,8'd15};
         6'd35: r = {8'd72, 8'd168,8'd124,8'd7,  8'd170,8'd35, 8'd135,8'd15};
         6'd36: r = {8'd72, 8'd156,8'd137,8'd7,  8'd170,8'd10, 8'd160,8'd15};
         6'd37: r = {8'd60, 8'd156,8'd137,8'd19, 8'd145,8'd10, 8'd160,8'd40};
         6'd38: r = {8'd47, 8'd156,8'd137,8'd32, 8'd170,8'd10, 8'd160,8'd15};
         6'd39: r = {8'd47, 8'd156,8'd137,8'd32, 8'd100,8'd80, 8'd90, 8'd90};
         default: r = '0;
      endcase
      pos = 3'(JOINT_MAX - 1) - joint;
      return r[pos*ANGLE_BITS +: ANGLE_BITS];
   endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/cubic_keyframe_servo_trajectory.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cubic_keyframe_servo_trajectory
// Zero-velocity cubic interpolation of eight servo joints between keyframe
// rows, with pulse width mapping.
//
// req channel: a start item loads a row range and segment duration and
// yields no result. A tick while moving yields one rsp transfer carrying
// all joint pulse widths; a tick while idle yields none. A moving tick
// holds req_stall high until its result enters the output register: one
// shared divider produces the 13-bit angle quotient one bit a cycle per
// joint, and the scale by 180 is a reciprocal multiply.
// The result sits in an output register; if rsp_stall holds it, a
// following start is still taken, and a following tick waits after its
// computation, with req_stall high, until the register frees.
// csr: pulse_low at byte 0, pulse_high at byte 4, write only while idle.
// Reset (synchronous) stops any move and restores 600 / 2400 us.
// ----------------------------------------------------------------------------
module cubic_keyframe_servo_trajectory
   import ckst_pkg::*;
#(
   parameter int JOINTS    = 8,
   parameter int ROWS      = 40,
   parameter int TIME_BITS = 12
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire req_type     req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output rsp_type          rsp_data,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   localparam int TB   = TIME_BITS;
   localparam int DENW = 3 * TB;
   localparam int SW   = 3 * TB + 2;
   localparam int NW   = 3 * TB + 8;
   localparam int NSW  = 3 * TB + 12;
   localparam int CW   = 17;
   localparam int PSW  = PULSE_BITS + 2;
   localparam int PRW  = ANGLE_BITS + PULSE_BITS;
   localparam int RCW  = PRW - 2 + RECIP_BITS;

   typedef enum logic [10:0] {
      ST_IDLE     = 11'b00000000001,
      ST_SQ       = 11'b00000000010,
      ST_CUBE     = 11'b00000000100,
      ST_PROD     = 11'b00000001000,
      ST_NUM      = 11'b00000010000,
      ST_ANG_GO   = 11'b00000100000,
      ST_ANG_WAIT = 11'b00001000000,
      ST_SCALE    = 11'b00010000000,
      ST_PUL_GO   = 11'b00100000000,
      ST_PUL_WAIT = 11'b01000000000,
      ST_OUT      = 11'b10000000000
   } state_type;

   state_type state_ff, state_in;

   logic [PULSE_BITS-1:0] low_ff, high_ff, hi_eff, span;
   logic [ROW_BITS-1:0]   row_ff, last_ff, row_next;
   logic [TB-1:0]         elapsed_ff, segment_ff, elapsed_next;
   logic                  moving_ff;
   logic [JOINT_BITS-1:0] joint_ff;
   logic [2*TB-1:0]       dsq_ff, esq_ff;
   logic [TB+1:0]         tri_ff;
   logic [DENW-1:0]       den_ff;
   logic [SW-1:0]         s_ff;
   logic [NW-1:0]         p0_ff, num_ff;
   logic signed [NSW-1:0] num_full;
   logic signed [ANGLE_BITS:0] dq_ff;
   logic [ANGLE_BITS-1:0] angle_ff, q0, q1;
   logic [PRW-1:0]        prod_ff;
   logic [RCW-1:0]        recip_ff;
   logic [PULSE_BITS-1:0] pulse_ff [JOINT_MAX];
   logic [PSW-1:0]        pulse_sum;
   rsp_type               rsp_ff;
   logic                  rsp_valid_ff;
   logic                  req_xfer, slot_free, last_joint, seg_end, done_flag;
   logic [ROW_BITS-1:0]   start_sat, end_sat;
   logic [CW-1:0]         dur_ext;
   logic [TB-1:0]         dur_sat;
   logic                  div_start, div_done;
   logic [NW-1:0]         div_dividend, div_divisor;
   logic [QUOT_BITS-1:0]  div_quot;

   // configuration port
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == REG_PULSE_HIGH) ? {20'b0, high_ff} : {20'b0, low_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         low_ff  <= 12'd600;
         high_ff <= 12'd2400;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         if (csr_paddr[2] == REG_PULSE_LOW) low_ff <= csr_pwdata[PULSE_BITS-1:0];
         else                               high_ff <= csr_pwdata[PULSE_BITS-1:0];
      end
   end

   assign hi_eff = (high_ff < low_ff) ? low_ff : high_ff;
   assign span   = hi_eff - low_ff;

   // handshake
   assign req_stall = (state_ff != ST_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign last_joint = (joint_ff == JOINT_BITS'(JOINTS - 1));

   // start item saturation
   assign start_sat = (req_data.start_index > ROW_BITS'(ROWS - 1)) ? ROW_BITS'(ROWS - 1)
                                                                   : req_data.start_index;
   assign end_sat   = (req_data.end_index > ROW_BITS'(ROWS - 1)) ? ROW_BITS'(ROWS - 1)
                                                                 : req_data.end_index;
   assign dur_ext   = CW'(req_data.duration_ms);
   always_comb begin
      if (dur_ext > CW'((1 << TB) - 1)) dur_sat = TB'((1 << TB) - 1);
      else if (dur_ext == '0)            dur_sat = TB'(1);
      else                               dur_sat = TB'(dur_ext);
   end

   // segment bookkeeping after a result
   assign elapsed_next = elapsed_ff + 1'b1;
   assign seg_end      = (elapsed_next >= segment_ff);
   assign row_next     = row_ff + 1'b1;
   assign done_flag    = seg_end && (row_next >= last_ff);

   assign q0 = rom_angle(row_ff, joint_ff);
   assign q1 = rom_angle(row_next, joint_ff);

   assign num_full = NSW'($signed({1'b0, p0_ff})) + NSW'(dq_ff) * NSW'($signed({1'b0, s_ff}));
   assign pulse_sum = PSW'(low_ff) + PSW'(recip_ff[RECIP_SHIFT +: QUOT_BITS]);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:     if (req_xfer && req_data.action == ACT_TICK && moving_ff) state_in = ST_SQ;
         ST_SQ:       state_in = ST_CUBE;
         ST_CUBE:     state_in = ST_PROD;
         ST_PROD:     state_in = ST_NUM;
         ST_NUM:      state_in = ST_ANG_GO;
         ST_ANG_GO:   state_in = ST_ANG_WAIT;
         ST_ANG_WAIT: if (div_done) state_in = ST_SCALE;
         ST_SCALE:    state_in = ST_PUL_GO;
         ST_PUL_GO:   state_in = ST_PUL_WAIT;
         ST_PUL_WAIT: state_in = last_joint ? ST_OUT : ST_PROD;
         ST_OUT:      if (slot_free) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   // motion state and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff       <= '0;
         last_ff      <= '0;
         elapsed_ff   <= '0;
         segment_ff   <= TB'(1);
         moving_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall) rsp_valid_ff <= 1'b0;
         if (req_xfer && req_data.action == ACT_START) begin
            row_ff     <= start_sat;
            last_ff    <= end_sat;
            segment_ff <= dur_sat;
            elapsed_ff <= '0;
            moving_ff  <= end_sat > start_sat;
         end
         if (state_ff == ST_OUT && slot_free) begin
            rsp_valid_ff <= 1'b1;
            if (seg_end) begin
               elapsed_ff <= '0;
               row_ff     <= row_next;
               if (done_flag) moving_ff <= 1'b0;
            end else begin
               elapsed_ff <= elapsed_next;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_OUT && slot_free) begin
         rsp_ff.pulse_joint0 <= (JOINTS > 0) ? pulse_ff[0] : '0;
         rsp_ff.pulse_joint1 <= (JOINTS > 1) ? pulse_ff[1] : '0;
         rsp_ff.pulse_joint2 <= (JOINTS > 2) ? pulse_ff[2] : '0;
         rsp_ff.pulse_joint3 <= (JOINTS > 3) ? pulse_ff[3] : '0;
         rsp_ff.pulse_joint4 <= (JOINTS > 4) ? pulse_ff[4] : '0;
         rsp_ff.pulse_joint5 <= (JOINTS > 5) ? pulse_ff[5] : '0;
         rsp_ff.pulse_joint6 <= (JOINTS > 6) ? pulse_ff[6] : '0;
         rsp_ff.pulse_joint7 <= (JOINTS > 7) ? pulse_ff[7] : '0;
         rsp_ff.segment_row  <= row_ff;
         rsp_ff.move_done    <= done_flag;
      end
   end

   // datapath, one step per state
   always_ff @(posedge clock) begin
      unique case (state_ff)
         ST_IDLE: joint_ff <= '0;
         ST_SQ: begin
            dsq_ff <= segment_ff * segment_ff;
            esq_ff <= elapsed_ff * elapsed_ff;
            tri_ff <= (TB+2)'(segment_ff) * (TB+2)'(3) - {1'b0, elapsed_ff, 1'b0};
         end
         ST_CUBE: begin
            den_ff <= DENW'(dsq_ff) * DENW'(segment_ff);
            s_ff   <= SW'(esq_ff) * SW'(tri_ff);
         end
         ST_PROD: begin
            p0_ff <= NW'(q0) * NW'(den_ff);
            dq_ff <= $signed({1'b0, q1}) - $signed({1'b0, q0});
         end
         ST_NUM:      num_ff <= num_full[NSW-1] ? '0 : NW'(num_full);
         ST_ANG_WAIT: if (div_done) angle_ff <= div_quot[ANGLE_BITS-1:0];
         ST_SCALE:    prod_ff <= PRW'(angle_ff) * PRW'(span);
         // offset = prod / 180 by reciprocal multiply
         ST_PUL_GO:   recip_ff <= RCW'(prod_ff[PRW-1:2]) * RCW'(RECIP_MUL);
         ST_PUL_WAIT: begin
            pulse_ff[joint_ff] <= (pulse_sum > PSW'(PULSE_MAX)) ? PULSE_BITS'(PULSE_MAX)
                                                                : PULSE_BITS'(pulse_sum);
            joint_ff <= joint_ff + 1'b1;
         end
         default: ;
      endcase
   end

   // shared divider: angle = num / den
   assign div_start    = (state_ff == ST_ANG_GO);
   assign div_dividend = num_ff;
   assign div_divisor  = NW'(den_ff);

   ckst_div #(.NW(NW)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quot)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_busy_stalls: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> req_stall) else $error("req taken while busy");
   a_elapsed_range: assert property (@(posedge clock) disable iff (reset)
      moving_ff |-> (elapsed_ff < segment_ff)) else $error("elapsed past segment");
   a_segment_nonzero: assert property (@(posedge clock) disable iff (reset)
      segment_ff != '0) else $error("zero segment duration");
   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_ANG_WAIT))
      else $error("divider done outside wait");

endmodule
`default_nettype wire

// ----- hw/rtl/ckst_div.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ckst_div
// Shared restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ckst_div
   import ckst_pkg::*;
#(
   parameter int NW = 44
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire logic [NW-1:0]        dividend,
   input  wire logic [NW-1:0]        divisor,
   output logic                      done,
   output logic [QUOT_BITS-1:0]      quotient
);

   localparam int SW = NW + QUOT_BITS - 1;
   localparam int CB = $clog2(QUOT_BITS);

   logic [SW-1:0]        rem_ff;
   logic [SW-1:0]        dsr_ff;
   logic [QUOT_BITS-1:0] quot_ff;
   logic [CB-1:0]        cnt_ff;
   logic                 busy_ff;
   logic                 done_ff;
   logic                 fits;

   assign fits = rem_ff >= dsr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CB'(QUOT_BITS - 1);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff  <= SW'(dividend);
         dsr_ff  <= {divisor, {(QUOT_BITS-1){1'b0}}};
         quot_ff <= '0;
      end else if (busy_ff) begin
         if (fits) rem_ff <= rem_ff - dsr_ff;
         dsr_ff  <= dsr_ff >> 1;
         quot_ff <= {quot_ff[QUOT_BITS-2:0], fits};
      end
   end

   assign done     = done_ff;
   assign quotient = quot_ff;

endmodule
`default_nettype wire

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the cubic keyframe servo trajectory block: start and tick requests
// with random gaps and back-pressure, each response compared whole against
// its prediction, pulse range registers swept across phases.
// ----------------------------------------------------------------------------
module testbench;
   import ckst_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_data;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   cubic_keyframe_servo_trajectory u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   initial forever #5 clock = ~clock;

   // predicted state
   logic [11:0] pl_low, pl_high;
   logic [5:0]  cur_row, end_row;
   logic [11:0] el_ms, seg_ms;
   logic        in_move;

   rsp_type     pulse_queue[$];
   int          errors = 0;
   int          ticks_sent = 0, starts_sent = 0, moves_done = 0, rsp_seen = 0;
   bit          no_idle = 0;

   function automatic logic [11:0] joint_width(int j);
      longint q0, q1, d, e, den, num, ang, hi, p;
      q0 = rom_angle(cur_row, 3'(j));
      q1 = rom_angle(cur_row + 6'd1, 3'(j));
      d = seg_ms; e = el_ms;
      den = d * d * d;
      num = q0 * den + (q1 - q0) * (e * e * (3 * d - 2 * e));
      if (num < 0) num = 0;
      ang = num / den;
      hi = (pl_high < pl_low) ? pl_low : pl_high;
      p = pl_low + ang * (hi - pl_low) / ANGLE_SPAN;
      return (p > PULSE_MAX) ? 12'(PULSE_MAX) : 12'(p);
   endfunction

   task automatic advance_trajectory(req_type r);
      rsp_type o;
      logic [11:0] w[8];
      if (r.action == ACT_START) begin
         cur_row = (r.start_index > 6'(ROM_ROWS - 1)) ? 6'(ROM_ROWS - 1) : r.start_index;
         end_row = (r.end_index > 6'(ROM_ROWS - 1)) ? 6'(ROM_ROWS - 1) : r.end_index;
         seg_ms = (r.duration_ms == 0) ? 12'd1 : r.duration_ms;
         el_ms = 0;
         in_move = end_row > cur_row;
         return;
      end
      if (!in_move) return;
      for (int j = 0; j < 8; j++) w[j] = joint_width(j);
      o = '{w[0], w[1], w[2], w[3], w[4], w[5], w[6], w[7], cur_row, 1'b0};
      el_ms++;
      if (el_ms >= seg_ms) begin
         el_ms = 0;
         cur_row++;
         if (cur_row >= end_row) begin
            in_move = 0;
            o.move_done = 1'b1;
         end
      end
      pulse_queue.push_back(o);
   endtask

   // valid stays high after a transfer only until the next call or drain
   task automatic send_req(logic act, logic [5:0] s, logic [5:0] e, logic [11:0] d);
      req_type r;
      r = '{act, s, e, d};
      while (!no_idle && $urandom_range(99) < 34) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      advance_trajectory(r);
      if (act == ACT_TICK) ticks_sent++; else starts_sent++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pulse_queue.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   task automatic csr_write(logic [2:0] addr, logic [11:0] v);
      csr_psel <= 1'b1; csr_pwrite <= 1'b1; csr_paddr <= addr; csr_pwdata <= 32'(v);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel <= 1'b0; csr_penable <= 1'b0; csr_pwrite <= 1'b0;
      if (addr == 3'(4 * REG_PULSE_LOW)) pl_low = v; else pl_high = v;
      @(posedge clock);
   endtask

   task automatic set_range(logic [11:0] lo, logic [11:0] hi);
      drain();
      csr_write(3'(4 * REG_PULSE_LOW), lo);
      csr_write(3'(4 * REG_PULSE_HIGH), hi);
   endtask

   always @(posedge clock) begin
      if (reset) rsp_stall <= 1'b0;
      else rsp_stall <= !no_idle && ($urandom_range(99) < 34);
   end

   always @(posedge clock) begin
      rsp_type x;
      if (!reset && rsp_valid && !rsp_stall) begin
         rsp_seen++;
         if (pulse_queue.size() == 0) begin
            $display("%0t unexpected response: expected none, actual %h", $time, rsp_data);
            errors++;
         end else begin
            x = pulse_queue.pop_front();
            if (rsp_data.move_done) moves_done++;
            if (x !== rsp_data) begin
               $display("%0t mismatch: expected %h actual %h", $time, x, rsp_data);
               if (x.pulse_joint0 !== rsp_data.pulse_joint0)
                  $display("%0t  joint0 expected %0d actual %0d", $time,
                           x.pulse_joint0, rsp_data.pulse_joint0);
               if (x.segment_row !== rsp_data.segment_row)
                  $display("%0t  segment_row expected %0d actual %0d", $time,
                           x.segment_row, rsp_data.segment_row);
               if (x.move_done !== rsp_data.move_done)
                  $display("%0t  move_done expected %0d actual %0d", $time,
                           x.move_done, rsp_data.move_done);
               errors++;
            end
         end
      end
   end

   task automatic test_directed();
      send_req(ACT_TICK, 0, 0, 0);         // tick while idle
      send_req(ACT_START, 0, 2, 0);        // zero duration taken as one
      repeat (3) send_req(ACT_TICK, 0, 0, 0);
      send_req(ACT_START, 5, 5, 3);        // empty range
      send_req(ACT_TICK, 0, 0, 0);
      send_req(ACT_START, 63, 63, 4095);   // saturated indices
      send_req(ACT_TICK, 0, 0, 0);
      send_req(ACT_START, 37, 63, 3);      // end saturated to last row
      repeat (4) send_req(ACT_TICK, 0, 0, 0);
      send_req(ACT_START, 10, 20, 4095);   // long segment, then abort
      repeat (3) send_req(ACT_TICK, 0, 0, 0);
      send_req(ACT_START, 0, 39, 1);
      repeat (6) send_req(ACT_TICK, 0, 0, 0);
   endtask

   task automatic test_random(int n);
      int r;
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(99);
         if (r < 8 || !in_move) begin
            if ($urandom_range(9) == 0)
               send_req(ACT_START, 6'($urandom), 6'($urandom), 12'($urandom));
            else if ($urandom_range(19) == 0)
               send_req(ACT_START, 6'($urandom_range(63)), 6'($urandom_range(63)),
                        12'($urandom_range(4095, 4000)));
            else
               send_req(ACT_START, 6'($urandom_range(38)), 6'($urandom_range(39)),
                        12'($urandom_range(6)));
         end else begin
            send_req(ACT_TICK, 6'($urandom), 6'($urandom), 12'($urandom));
         end
      end
   endtask

   initial begin
      pl_low = 600; pl_high = 2400;
      cur_row = 0; end_row = 0; el_ms = 0; seg_ms = 1; in_move = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(300);
      set_range(12'd0, 12'd4095);
      test_random(200);
      no_idle = 1;
      set_range(12'd4095, 12'd0);          // high below low
      test_random(150);
      no_idle = 0;
      set_range(12'd3000, 12'd4095);
      test_random(150);
      set_range(12'd1234, 12'd2890);
      test_random(250);
      drain();
      $display("covered %0d starts and %0d ticks, %0d responses, %0d completed moves",
               starts_sent, ticks_sent, rsp_seen, moves_done);
      $display("pulse ranges swept over default, full span, inverted and high offset");
      if (errors == 0 && pulse_queue.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("CHECKS FAILED");
      $finish;
   end
endmodule
